>>> rtl/ctt_pkg.sv
package ctt_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned TickW   = 8;
  localparam int unsigned TempoW  = 24;
  localparam int unsigned SrcW    = 2;
  localparam int unsigned NumW    = 38;  // 255 * 640e6 fits in 38 bits
  localparam int unsigned ConstW  = 30;
  localparam int unsigned DivSteps = NumW;
  localparam int unsigned CntW    = $clog2(DivSteps);

  localparam logic [NumW-1:0]   SyncNum  = NumW'(64'd7680000000);
  localparam logic [ConstW-1:0] MidiNum  = ConstW'(64'd640000000);
  localparam logic [TempoW-1:0] TempoMax = '1;

  localparam logic [SrcW-1:0] SrcInternal = 2'd0;
  localparam logic [SrcW-1:0] SrcMidi     = 2'd1;
  localparam logic [SrcW-1:0] SrcSync     = 2'd2;

  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic out_load;
  } ctt_cmd_t;

  typedef struct packed {
    logic div_need;
    logic out_free;
  } ctt_stat_t;

endpackage

>>> rtl/ctt_if.sv
interface ctt_upd_if;
  import ctt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  now_us;
  logic              cable_connected;
  logic              midi_tempo_present;
  logic              sync_tick_seen;
  logic [TimeW-1:0]  sync_tick_time_us;
  logic [TickW-1:0]  midi_ticks;

  modport source (output valid, now_us, cable_connected, midi_tempo_present,
                  sync_tick_seen, sync_tick_time_us, midi_ticks, input ready);
  modport sink   (input valid, now_us, cable_connected, midi_tempo_present,
                  sync_tick_seen, sync_tick_time_us, midi_ticks, output ready);
endinterface

interface ctt_res_if;
  import ctt_pkg::*;
  logic              valid;
  logic              ready;
  logic [SrcW-1:0]   source_now;
  logic              tempo_valid;
  logic [TempoW-1:0] tempo_q8;
  logic              resync_pulse;
  logic              midi_reset_pulse;

  modport source (output valid, source_now, tempo_valid, tempo_q8, resync_pulse,
                  midi_reset_pulse, input ready);
  modport sink   (input valid, source_now, tempo_valid, tempo_q8, resync_pulse,
                  midi_reset_pulse, output ready);
endinterface

>>> rtl/ctt_dp.sv
module ctt_dp
  import ctt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctt_cmd_t  cmd_i,
  output ctt_stat_t stat_o,
  ctt_upd_if.sink   upd,
  ctt_res_if.source res
);

  // latched request
  logic [TimeW-1:0] now_q, tick_time_q;
  logic             cable_q, midi_q, tick_q;
  logic [TickW-1:0] ticks_q;

  // tracker state
  logic [SrcW-1:0]  src_q, src_d;
  logic [TimeW-1:0] rt_q, rt_d;
  logic             rv_q, rv_d;

  // pending result
  logic             valid_q, resync_q, mreset_q;
  logic             need_d;

  // divider
  logic [TimeW-1:0] den_q, den_d;
  logic [TimeW-1:0] rem_q;
  logic [NumW-1:0]  quo_q, num_d;
  logic [TimeW:0]   rem_sh, rem_sub;
  logic             q_bit;

  // output slot
  logic              ov_q;
  logic [SrcW-1:0]   o_src_q;
  logic              o_tv_q, o_rs_q, o_mr_q;
  logic [TempoW-1:0] o_tempo_q, tempo_sat;

  logic [SrcW-1:0]  want;
  logic             changed, evt, resync_d, mreset_d;
  logic [TimeW-1:0] evt_time, rt_base;
  logic             rv_base;

  always_comb begin
    if (cable_q) begin
      want = SrcSync;
    end else if (midi_q) begin
      want = SrcMidi;
    end else begin
      want = SrcInternal;
    end
    changed  = (want != src_q);
    mreset_d = changed && (src_q == SrcMidi);
    rt_base  = changed ? '0 : rt_q;
    rv_base  = changed ? 1'b0 : rv_q;
    src_d    = want;
    resync_d = 1'b0;
    evt      = 1'b0;
    evt_time = now_q;
    if (want == SrcSync) begin
      if (tick_q) begin
        resync_d = 1'b1;
        evt      = 1'b1;
        evt_time = tick_time_q;
      end
    end else if (want == SrcMidi) begin
      evt = (ticks_q != '0);
    end
    need_d = evt && rv_base && (evt_time > rt_base);
    den_d  = evt_time - rt_base;
    rt_d   = evt ? evt_time : rt_base;
    rv_d   = evt ? 1'b1 : rv_base;
    num_d  = (want == SrcSync) ? SyncNum : NumW'(ticks_q) * NumW'(MidiNum);
  end

  // restoring division, one quotient bit per step
  always_comb begin
    rem_sh  = {rem_q, quo_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    q_bit   = (rem_sh >= {1'b0, den_q});
  end

  assign tempo_sat = (|quo_q[NumW-1:TempoW]) ? TempoMax : quo_q[TempoW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      now_q       <= upd.now_us;
      cable_q     <= upd.cable_connected;
      midi_q      <= upd.midi_tempo_present;
      tick_q      <= upd.sync_tick_seen;
      tick_time_q <= upd.sync_tick_time_us;
      ticks_q     <= upd.midi_ticks;
    end
    if (cmd_i.eval) begin
      valid_q  <= need_d;
      resync_q <= resync_d;
      mreset_q <= mreset_d;
      den_q    <= den_d;
      quo_q    <= num_d;
      rem_q    <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= q_bit ? rem_sub[TimeW-1:0] : rem_sh[TimeW-1:0];
      quo_q <= {quo_q[NumW-2:0], q_bit};
    end
    if (cmd_i.out_load) begin
      o_src_q   <= src_q;
      o_tv_q    <= valid_q;
      o_tempo_q <= valid_q ? tempo_sat : '0;
      o_rs_q    <= resync_q;
      o_mr_q    <= mreset_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= SrcInternal;
      rt_q  <= '0;
      rv_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (cmd_i.eval) begin
        src_q <= src_d;
        rt_q  <= rt_d;
        rv_q  <= rv_d;
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (res.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign stat_o.div_need = need_d;
  assign stat_o.out_free = !ov_q || res.ready;

  assign res.valid            = ov_q;
  assign res.source_now       = o_src_q;
  assign res.tempo_valid      = o_tv_q;
  assign res.tempo_q8         = o_tempo_q;
  assign res.resync_pulse     = o_rs_q;
  assign res.midi_reset_pulse = o_mr_q;

endmodule

>>> rtl/ctt_ctrl.sv
module ctt_ctrl
  import ctt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctt_stat_t stat_i,
  output ctt_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StEval,
    StDiv,
    StDone
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = (state_q == StIdle) && in_valid_i;
    cmd_o.eval     = (state_q == StEval);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.out_load = (state_q == StDone) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            state_q <= StEval;
          end
        end
        StEval: begin
          cnt_q   <= '0;
          state_q <= stat_i.div_need ? StDiv : StDone;
        end
        StDiv: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (stat_i.out_free) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/clock_source_tempo_tracker_unit.sv
// Tempo source tracker. Each update request picks sync, MIDI or internal
// clock, tracks the reference time and reports the derived tempo as unsigned
// Q16.8 BPM together with resync and MIDI reset pulses, one result per
// request. An accepted update is evaluated; when a tempo is derived it then
// runs the 38 steps of the bit-serial restoring divider, and its result is
// loaded into the output register once that register is free.
// The result sits in an output register, so the next request is taken once
// the result has been loaded, even if it has not been taken yet.
module clock_source_tempo_tracker_unit
  import ctt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  ctt_upd_if.sink   upd_i,
  ctt_res_if.source res_o
);

  ctt_cmd_t  cmd;
  ctt_stat_t stat;
  logic      in_ready;

  assign upd_i.ready = in_ready;

  ctt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (upd_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ctt_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .upd    (upd_i),
    .res    (res_o)
  );

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ctt_pkg::*;

  typedef struct packed {
    logic [TimeW-1:0] now;
    logic             cable;
    logic             midi;
    logic             tick;
    logic [TimeW-1:0] tick_time;
    logic [TickW-1:0] ticks;
  } upd_req_t;

  typedef struct packed {
    logic [SrcW-1:0]   src;
    logic              tempo_valid;
    logic [TempoW-1:0] tempo;
    logic              resync;
    logic              midi_reset;
  } tempo_res_t;

  logic clk;
  logic rst_n;

  ctt_upd_if upd ();
  ctt_res_if res ();

  clock_source_tempo_tracker_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .upd_i  (upd),
    .res_o  (res)
  );

  upd_req_t   upd_pending[$];
  tempo_res_t tempo_expected[$];
  upd_req_t   cur_req;
  tempo_res_t seen_res;
  tempo_res_t want_res;
  int unsigned mismatches;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // tracker state as the block should hold it
  logic [SrcW-1:0]  cur_src;
  logic [TimeW-1:0] ref_stamp;
  logic             ref_stamp_ok;

  // random sequence generator state
  int unsigned      run_left;
  int unsigned      run_mode;
  logic [TimeW-1:0] gen_now;

  function automatic tempo_res_t track_update(input upd_req_t r);
    tempo_res_t      o;
    logic [SrcW-1:0] want;
    logic [63:0]     num;
    logic [63:0]     den;
    logic [63:0]     q;
    o = '0;
    num = 64'd0;
    den = 64'd0;
    want = r.cable ? SrcSync : (r.midi ? SrcMidi : SrcInternal);
    if (want != cur_src) begin
      o.midi_reset = (cur_src == SrcMidi);
      cur_src = want;
      ref_stamp_ok = 1'b0;
      ref_stamp = '0;
    end
    if (cur_src == SrcSync && r.tick) begin
      o.resync = 1'b1;
      if (ref_stamp_ok && r.tick_time > ref_stamp) begin
        num = 64'(SyncNum);
        den = 64'(r.tick_time - ref_stamp);
      end
      ref_stamp = r.tick_time;
      ref_stamp_ok = 1'b1;
    end else if (cur_src == SrcMidi && r.ticks != '0) begin
      if (ref_stamp_ok && r.now > ref_stamp) begin
        num = 64'(r.ticks) * 64'(MidiNum);
        den = 64'(r.now - ref_stamp);
      end
      ref_stamp = r.now;
      ref_stamp_ok = 1'b1;
    end
    if (den != 64'd0) begin
      q = num / den;
      o.tempo_valid = 1'b1;
      o.tempo = (q > 64'(TempoMax)) ? TempoMax : q[TempoW-1:0];
    end
    o.src = cur_src;
    return o;
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom(), $urandom()});
  endfunction

  task automatic add_req(input logic [TimeW-1:0] now, input logic cable, input logic midi,
                         input logic tick, input logic [TimeW-1:0] tick_time,
                         input logic [TickW-1:0] ticks);
    upd_pending.push_back('{now, cable, midi, tick, tick_time, ticks});
  endtask

  task automatic push_random(input int unsigned n);
    upd_req_t    r;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      if (run_left == 0) begin
        run_mode = $urandom_range(2);
        run_left = $urandom_range(4, 16);
        if ($urandom_range(3) == 0) gen_now = rand_time();
      end
      run_left--;
      r.now       = rand_time();
      r.cable     = 1'($urandom());
      r.midi      = 1'($urandom());
      r.tick      = 1'($urandom());
      r.tick_time = rand_time();
      r.ticks     = TickW'($urandom());
      if ($urandom_range(99) >= 15) begin
        // well-formed step: time moves on, mostly forward
        pick = $urandom_range(99);
        if (pick < 5) gen_now = gen_now;
        else if (pick < 10) gen_now = gen_now - TimeW'($urandom_range(1, 1000));
        else if (pick < 18) gen_now = gen_now + TimeW'($urandom_range(1, 500));
        else gen_now = gen_now + TimeW'($urandom_range(1, 300000));
        case (run_mode)
          0: begin
            r.cable = 1'b0;
            r.midi  = 1'b0;
          end
          1: begin
            r.cable = 1'b0;
            r.midi  = 1'b1;
            r.now   = gen_now;
            pick = $urandom_range(9);
            if (pick == 0) r.ticks = '0;
            else if (pick == 1) r.ticks = TickW'($urandom_range(49, 255));
            else r.ticks = TickW'($urandom_range(1, 48));
          end
          default: begin
            r.cable     = 1'b1;
            r.tick      = ($urandom_range(3) != 0);
            r.tick_time = gen_now;
            r.now       = gen_now + TimeW'($urandom_range(0, 100));
          end
        endcase
      end
      upd_pending.push_back(r);
    end
  endtask

  task automatic drain();
    while (upd_pending.size() != 0 || upd.valid || tempo_expected.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    upd.valid = 1'b0;
    upd.now_us = '0;
    upd.cable_connected = 1'b0;
    upd.midi_tempo_present = 1'b0;
    upd.sync_tick_seen = 1'b0;
    upd.sync_tick_time_us = '0;
    upd.midi_ticks = '0;
    res.ready = 1'b0;
    forever #6 clk = ~clk;
  end

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      upd.valid <= 1'b0;
      cur_src = SrcInternal;
      ref_stamp = '0;
      ref_stamp_ok = 1'b0;
    end else begin
      if (upd.valid && upd.ready) tempo_expected.push_back(track_update(cur_req));
      if (!upd.valid || upd.ready) begin
        if (upd_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          cur_req = upd_pending.pop_front();
          upd.now_us <= cur_req.now;
          upd.cable_connected <= cur_req.cable;
          upd.midi_tempo_present <= cur_req.midi;
          upd.sync_tick_seen <= cur_req.tick;
          upd.sync_tick_time_us <= cur_req.tick_time;
          upd.midi_ticks <= cur_req.ticks;
          upd.valid <= 1'b1;
        end else begin
          upd.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        seen_res = '{res.source_now, res.tempo_valid, res.tempo_q8, res.resync_pulse,
                     res.midi_reset_pulse};
        if (tempo_expected.size() == 0) begin
          if (mismatches < 10)
            $display("%t: result with no request pending: src=%0d tv=%0b tempo=%0d rs=%0b mr=%0b",
                     $realtime, seen_res.src, seen_res.tempo_valid, seen_res.tempo,
                     seen_res.resync, seen_res.midi_reset);
          mismatches++;
        end else begin
          want_res = tempo_expected.pop_front();
          if (seen_res.src !== want_res.src || seen_res.tempo_valid !== want_res.tempo_valid ||
              seen_res.tempo !== want_res.tempo || seen_res.resync !== want_res.resync ||
              seen_res.midi_reset !== want_res.midi_reset) begin
            if (mismatches < 10)
              $display("%t: mismatch exp src=%0d tv=%0b tempo=%0d rs=%0b mr=%0b, got src=%0d tv=%0b tempo=%0d rs=%0b mr=%0b",
                       $realtime, want_res.src, want_res.tempo_valid, want_res.tempo,
                       want_res.resync, want_res.midi_reset, seen_res.src,
                       seen_res.tempo_valid, seen_res.tempo, seen_res.resync,
                       seen_res.midi_reset);
            mismatches++;
          end
        end
      end
      res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    mismatches = 0;
    run_left = 0;
    run_mode = 0;
    gen_now = '0;
    tx_idle_pct = 33;
    rx_idle_pct = 84;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // internal source ignores everything else
    add_req(48'd0, 1'b0, 1'b0, 1'b0, 48'd0, 8'd0);
    add_req('1, 1'b0, 1'b0, 1'b1, '1, 8'hFF);
    // MIDI: entry, first ticks set the reference, then 120 BPM, saturation,
    // same time, time going back, widest interval
    add_req(48'd1000, 1'b0, 1'b1, 1'b0, 48'd0, 8'd0);
    add_req(48'd2000, 1'b0, 1'b1, 1'b1, '1, 8'd24);
    add_req(48'd502000, 1'b0, 1'b1, 1'b0, 48'd0, 8'd24);
    add_req(48'd502001, 1'b0, 1'b1, 1'b0, 48'd0, 8'hFF);
    add_req(48'd502001, 1'b0, 1'b1, 1'b0, 48'd0, 8'd1);
    add_req(48'd400000, 1'b0, 1'b1, 1'b0, 48'd0, 8'd1);
    add_req('1, 1'b0, 1'b1, 1'b0, 48'd0, 8'hFF);
    // cable wins over MIDI; leaving MIDI pulses its reset
    add_req(48'd10, 1'b1, 1'b1, 1'b1, 48'd100, 8'd0);
    add_req(48'd20, 1'b1, 1'b0, 1'b1, 48'd500100, 8'd0);
    add_req(48'd30, 1'b1, 1'b0, 1'b0, 48'd0, 8'd0);
    add_req(48'd40, 1'b1, 1'b0, 1'b1, 48'd500101, 8'd0);
    add_req(48'd50, 1'b1, 1'b0, 1'b1, 48'd500101, 8'd0);
    add_req(48'd60, 1'b1, 1'b0, 1'b1, 48'd3, 8'd0);
    add_req(48'd70, 1'b1, 1'b0, 1'b1, '1, 8'd0);
    // sync to MIDI raises no reset, MIDI to internal does
    add_req(48'd80, 1'b0, 1'b1, 1'b1, 48'd0, 8'd8);
    add_req(48'd1000080, 1'b0, 1'b1, 1'b0, 48'd0, 8'd48);
    add_req(48'd1000090, 1'b0, 1'b0, 1'b1, 48'd0, 8'd5);
    // reference at time zero, then a one microsecond interval
    add_req(48'd1000100, 1'b1, 1'b0, 1'b1, 48'd0, 8'd0);
    add_req(48'd1000110, 1'b1, 1'b0, 1'b1, 48'd1, 8'd0);
    add_req(48'd1000120, 1'b0, 1'b0, 1'b0, 48'd0, 8'd0);
    push_random(185);
    drain();

    tx_idle_pct = 84;
    rx_idle_pct = 33;
    push_random(185);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    push_random(180);
    drain();

    repeat (50) @(negedge clk);
    if (mismatches == 0 && tempo_expected.size() == 0) begin
      $display("[clock_source_tempo_tracker_unit] OK");
    end else begin
      $display("[clock_source_tempo_tracker_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[clock_source_tempo_tracker_unit] ERROR");
    $finish;
  end

endmodule
